// ----- hw/rtl/dtsvf_pkg.sv -----
// Shared constants, register indexes and sequencer states for the dual temperature filter.
package dtsvf_pkg;

  // Primary converter resolution and derived code limits
  localparam int ADC_BITS = 12;
  localparam int CODE_W   = 12;
  localparam int CODE_MAX = 2**ADC_BITS - 1;
  localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'(CODE_MAX);
  localparam int CMP_W    = ((ADC_BITS > CODE_W) ? ADC_BITS : CODE_W) + 1;
  localparam int CODE_EDGE = 5;

  // Field and register widths
  localparam int REF_W   = 23;
  localparam int OFS_W   = 21;
  localparam int SLOPE_W = 24;
  localparam int TEMP_W  = 16;
  localparam int ALPHA_W = 17;
  localparam int DIS_W   = 15;
  localparam int SUV_W   = 24;

  // Shared multiplier: signed A times unsigned B
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Inverse slope is applied in two halves
  localparam int SLOPE_LO_W = 12;
  localparam int SLOPE_HI_W = SLOPE_W - SLOPE_LO_W;

  // Datapath widths
  localparam int DIV_W      = CODE_W + REF_W;
  localparam int QUO_W      = REF_W + 1;
  localparam int UV_W       = 27;
  localparam int ACC_W      = 51;
  localparam int TEMP_SHIFT = 24;
  localparam int T_W        = ACC_W - TEMP_SHIFT;
  localparam int FRAC_W     = 16;
  localparam int ST_W       = TEMP_W + FRAC_W;
  localparam int FD_W       = ST_W + 1;

  localparam int MARGIN_UV = 50000;
  localparam int ALPHA_ONE = 65536;

  // Stream word widths
  localparam int IN_USED  = CODE_W + SUV_W + 1;
  localparam int IN_W     = ((IN_USED + 7) / 8) * 8;
  localparam int OUT_USED = 3 * TEMP_W + 3;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_REF_VOLTAGE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_OFS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SLOPE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISAGREE = 3'd6;

  // Register reset values
  localparam logic [REF_W-1:0]          REF_RST   = REF_W'(3300000);
  localparam logic [OFS_W-1:0]          OFS_RST   = OFS_W'(500000);
  localparam logic [SLOPE_W-1:0]        SLOPE_RST = SLOPE_W'(429497);
  localparam logic signed [TEMP_W-1:0]  MIN_RST   = TEMP_W'(-10240);
  localparam logic signed [TEMP_W-1:0]  MAX_RST   = TEMP_W'(32000);
  localparam logic [ALPHA_W-1:0]        ALPHA_RST = ALPHA_W'(6554);
  localparam logic [DIS_W-1:0]          DIS_RST   = DIS_W'(5120);

  // Channel select
  localparam logic CH_PRI = 1'b0;
  localparam logic CH_SEC = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PLOAD,
    ST_PDIV,
    ST_SUB,
    ST_CMUL_LO,
    ST_CMUL_HI,
    ST_CACC,
    ST_CHECK,
    ST_FSUB,
    ST_FMUL_HI,
    ST_FMUL_LO,
    ST_FACC,
    ST_FUPD,
    ST_CHDONE,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/dual_temp_sensor_validate_filter_unit.sv -----
// Dual temperature sensor check and exponential filter, sequenced over one shared multiplier.
//
// Input stream (s_t*): one word per sample pair: primary converter code, secondary
// reading in microvolts and the secondary read-ok flag. Output stream (m_t*): one word
// per input word with both filtered temperatures, their ok flags, the agreement flag
// and the process temperature. Configuration (cfg_*) writes one register per handshake;
// cfg_ready is always high, and writes belong between items.
// Each word passes from acceptance to the result register through these steps: the primary
// product through a single 27x17 multiplier, the divide by the converter full scale (an
// end-around fold of up to three steps), then for each channel conversion, check and
// hand-over plus a filter update when the reading is good and the filter already seeded,
// and the load of the output register. The sequencer returns to idle before the next
// word is accepted.
// s_tready is high only while the sequencer is idle. The result sits in an output
// register, so a new word is accepted while the previous result waits; a finished
// result waits in the sequencer if the output register is still full.
// Reset (rst, synchronous) loads the default register values, clears both filters and
// their seeded flags, and empties the output register.
module dual_temp_sensor_validate_filter_unit
  import dtsvf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [11:0] primary_code, [35:12] secondary_uv, [36] secondary_read_ok, rest zero
  input  logic [IN_W-1:0]       s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] primary_ok, [16:1] primary_temp, [17] secondary_ok, [33:18] secondary_temp,
  // [34] both_agree, [50:35] process_temp, rest zero
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [REF_W-1:0]         ref_voltage_uv;
  logic [OFS_W-1:0]         sensor_offset_uv;
  logic [SLOPE_W-1:0]       inverse_slope;
  logic signed [TEMP_W-1:0] min_temp;
  logic signed [TEMP_W-1:0] max_temp;
  logic [ALPHA_W-1:0]       filter_alpha;
  logic [DIS_W-1:0]         max_disagree;

  // Filter state
  logic signed [ST_W-1:0] primary_filtered;
  logic signed [ST_W-1:0] secondary_filtered;
  logic                   primary_seeded;
  logic                   secondary_seeded;

  // Sequencer and working registers
  state_t                    state;
  state_t                    state_next;
  logic                      ch;
  logic [CODE_W-1:0]         code;
  logic signed [SUV_W-1:0]   sec_uv;
  logic                      sec_read;
  logic                      pre_ok;
  logic [DIV_W-1:0]          y;
  logic [QUO_W-1:0]          quo;
  logic signed [UV_W-1:0]    uv;
  logic signed [UV_W-1:0]    dv;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [TEMP_W-1:0]  t_reg;
  logic signed [FD_W-1:0]    fd;
  logic                      p_ok;
  logic                      s_ok;
  logic signed [TEMP_W-1:0]  p_rep;
  logic signed [TEMP_W-1:0]  s_rep;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_a_ext;
  logic signed [PROD_W-1:0]  mul_b_ext;
  logic signed [PROD_W-1:0]  mul_p;

  // Combinational helpers
  logic [CODE_W-1:0]        in_code;
  logic [CMP_W-1:0]         code_cmp;
  logic                     code_ok;
  logic [DIV_W-1:0]         y_hi;
  logic [DIV_W-1:0]         y_lo;
  logic                     y_big;
  logic [QUO_W-1:0]         quo_final;
  logic signed [UV_W-1:0]   uv_lo_lim;
  logic signed [UV_W-1:0]   uv_hi_lim;
  logic signed [T_W-1:0]    t_full;
  logic signed [TEMP_W-1:0] t16;
  logic                     chan_ok;
  logic signed [ST_W-1:0]   st_cur;
  logic                     seeded_cur;
  logic signed [ST_W-1:0]   st_new;
  logic [ALPHA_W-1:0]       alpha_eff;
  logic                     out_free;
  logic signed [TEMP_W:0]   rep_diff;
  logic [TEMP_W:0]          rep_abs;
  logic                     agree;
  logic signed [TEMP_W-1:0] proc_temp;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Input code checks
  assign in_code  = s_tdata[CODE_W-1:0] & CODE_MASK;
  assign code_cmp = CMP_W'(in_code);
  assign code_ok  = (code_cmp > CMP_W'(CODE_EDGE)) && (code_cmp < CMP_W'(CODE_MAX - CODE_EDGE));

  // Fold step for divide by 2^ADC_BITS - 1
  assign y_hi      = y >> ADC_BITS;
  assign y_lo      = y & DIV_W'(CODE_MAX);
  assign y_big     = (y_hi != '0);
  assign quo_final = quo + QUO_W'(y == DIV_W'(CODE_MAX));

  // Plausibility of the current channel
  assign uv_lo_lim = UV_W'(MARGIN_UV);
  assign uv_hi_lim = $signed(UV_W'(ref_voltage_uv)) - UV_W'(MARGIN_UV);
  assign t_full    = $signed(acc[ACC_W-1:TEMP_SHIFT]);
  assign t16       = t_full[TEMP_W-1:0];
  assign chan_ok   = pre_ok && (uv > uv_lo_lim) && (uv < uv_hi_lim) &&
                     (t_full >= T_W'(min_temp)) && (t_full <= T_W'(max_temp));

  // Current channel filter state
  assign st_cur     = (ch == CH_SEC) ? secondary_filtered : primary_filtered;
  assign seeded_cur = (ch == CH_SEC) ? secondary_seeded : primary_seeded;
  assign st_new     = st_cur + $signed(acc[ST_W-1:0]);
  assign alpha_eff  = (filter_alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : filter_alpha;

  // Result fields
  assign rep_diff  = (TEMP_W+1)'(p_rep) - (TEMP_W+1)'(s_rep);
  assign rep_abs   = rep_diff[TEMP_W] ? $unsigned(-rep_diff) : $unsigned(rep_diff);
  assign agree     = p_ok && s_ok && (rep_abs < (TEMP_W+1)'(max_disagree));
  assign proc_temp = (p_rep > s_rep) ? p_rep : s_rep;

  // Multiply with operands extended to full product width
  assign mul_a_ext = PROD_W'(mul_a);
  assign mul_b_ext = $signed(PROD_W'(mul_b));
  assign mul_p     = mul_a_ext * mul_b_ext;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_PMUL;
      ST_PMUL:    state_next = ST_PLOAD;
      ST_PLOAD:   state_next = ST_PDIV;
      ST_PDIV:    if (!y_big) state_next = ST_SUB;
      ST_SUB:     state_next = ST_CMUL_LO;
      ST_CMUL_LO: state_next = ST_CMUL_HI;
      ST_CMUL_HI: state_next = ST_CACC;
      ST_CACC:    state_next = ST_CHECK;
      ST_CHECK:   state_next = (chan_ok && seeded_cur) ? ST_FSUB : ST_CHDONE;
      ST_FSUB:    state_next = ST_FMUL_HI;
      ST_FMUL_HI: state_next = ST_FMUL_LO;
      ST_FMUL_LO: state_next = ST_FACC;
      ST_FACC:    state_next = ST_FUPD;
      ST_FUPD:    state_next = ST_CHDONE;
      ST_CHDONE:  state_next = (ch == CH_PRI) ? ST_SUB : ST_FINISH;
      ST_FINISH:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Handshake and multiplier operand select
  always_comb begin
    s_tready = (state == ST_IDLE);
    mul_a    = dv;
    mul_b    = MUL_B_W'(inverse_slope[SLOPE_LO_W-1:0]);
    unique case (state)
      ST_PMUL: begin
        mul_a = $signed(MUL_A_W'(ref_voltage_uv));
        mul_b = MUL_B_W'(code);
      end
      ST_CMUL_HI: begin
        mul_b = MUL_B_W'(inverse_slope[SLOPE_W-1:SLOPE_LO_W]);
      end
      ST_FMUL_HI: begin
        mul_a = MUL_A_W'($signed(fd[FD_W-1:FRAC_W]));
        mul_b = alpha_eff;
      end
      ST_FMUL_LO: begin
        mul_a = $signed(MUL_A_W'(fd[FRAC_W-1:0]));
        mul_b = alpha_eff;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_voltage_uv   <= REF_RST;
      sensor_offset_uv <= OFS_RST;
      inverse_slope    <= SLOPE_RST;
      min_temp         <= MIN_RST;
      max_temp         <= MAX_RST;
      filter_alpha     <= ALPHA_RST;
      max_disagree     <= DIS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REF_VOLTAGE:  ref_voltage_uv   <= cfg_data[REF_W-1:0];
        REG_SENSOR_OFS:   sensor_offset_uv <= cfg_data[OFS_W-1:0];
        REG_INV_SLOPE:    inverse_slope    <= cfg_data[SLOPE_W-1:0];
        REG_MIN_TEMP:     min_temp         <= $signed(cfg_data[TEMP_W-1:0]);
        REG_MAX_TEMP:     max_temp         <= $signed(cfg_data[TEMP_W-1:0]);
        REG_FILTER_ALPHA: filter_alpha     <= cfg_data[ALPHA_W-1:0];
        REG_MAX_DISAGREE: max_disagree     <= cfg_data[DIS_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter state: seed on the first good reading, then step toward each later good reading
  always_ff @(posedge clk) begin
    if (rst) begin
      primary_filtered   <= '0;
      secondary_filtered <= '0;
      primary_seeded     <= 1'b0;
      secondary_seeded   <= 1'b0;
    end else if (state == ST_CHECK && chan_ok && !seeded_cur) begin
      if (ch == CH_SEC) begin
        secondary_filtered <= $signed({t16, {FRAC_W{1'b0}}});
        secondary_seeded   <= 1'b1;
      end else begin
        primary_filtered <= $signed({t16, {FRAC_W{1'b0}}});
        primary_seeded   <= 1'b1;
      end
    end else if (state == ST_FUPD) begin
      if (ch == CH_SEC) begin
        secondary_filtered <= st_new;
      end else begin
        primary_filtered <= st_new;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // capture the input word
        code     <= in_code;
        sec_uv   <= $signed(s_tdata[CODE_W+SUV_W-1:CODE_W]);
        sec_read <= s_tdata[CODE_W+SUV_W];
        pre_ok   <= code_ok;
        ch       <= CH_PRI;
      end
      ST_PMUL: begin
        prod <= mul_p;
      end
      ST_PLOAD: begin
        y   <= prod[DIV_W-1:0];
        quo <= '0;
      end
      ST_PDIV: begin
        // fold high part into low part until it fits in ADC_BITS bits
        if (y_big) begin
          quo <= quo + QUO_W'(y_hi);
          y   <= y_hi + y_lo;
        end else begin
          uv <= $signed(UV_W'(quo_final));
        end
      end
      ST_SUB: begin
        dv <= uv - $signed(UV_W'(sensor_offset_uv));
      end
      ST_CMUL_LO: begin
        prod <= mul_p;
      end
      ST_CMUL_HI: begin
        acc  <= ACC_W'(prod);
        prod <= mul_p;
      end
      ST_CACC: begin
        acc <= acc + (ACC_W'(prod) <<< SLOPE_LO_W);
      end
      ST_CHECK: begin
        t_reg <= t16;
        if (ch == CH_SEC) begin
          s_ok  <= chan_ok;
          s_rep <= chan_ok ? t16 : '0;
        end else begin
          p_ok  <= chan_ok;
          p_rep <= chan_ok ? t16 : '0;
        end
      end
      ST_FSUB: begin
        fd <= FD_W'($signed({t_reg, {FRAC_W{1'b0}}})) - FD_W'(st_cur);
      end
      ST_FMUL_HI: begin
        prod <= mul_p;
      end
      ST_FMUL_LO: begin
        acc  <= ACC_W'(prod);
        prod <= mul_p;
      end
      ST_FACC: begin
        acc <= acc + ACC_W'(prod >>> FRAC_W);
      end
      ST_FUPD: begin
        if (ch == CH_SEC) begin
          s_rep <= st_new[ST_W-1:FRAC_W];
        end else begin
          p_rep <= st_new[ST_W-1:FRAC_W];
        end
      end
      ST_CHDONE: begin
        // advance to the secondary channel
        if (ch == CH_PRI) begin
          ch     <= CH_SEC;
          uv     <= UV_W'(sec_uv);
          pre_ok <= sec_read;
        end
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= {{(OUT_W-OUT_USED){1'b0}}, proc_temp, agree, s_rep, s_ok, p_rep, p_ok};
    end
  end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the dual temperature sensor check and filter unit.
module testbench
  import dtsvf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int SETTLE       = 40;    // cycles of quiet before a register write
  localparam int DRAIN        = 64;    // cycles of quiet after the last result
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 3000;  // watchdog: cycles with no handshake at all
  localparam int N_DIRECTED   = 17;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register behind it

  // Result word, lowest field last
  typedef struct packed {
    logic [OUT_W-OUT_USED-1:0] pad;
    logic signed [TEMP_W-1:0]  proc_temp;
    logic                      agree;
    logic signed [TEMP_W-1:0]  sec_temp;
    logic                      sec_ok;
    logic signed [TEMP_W-1:0]  pri_temp;
    logic                      pri_ok;
  } reading_t;

  typedef struct packed {
    logic [11:0]        code;
    logic signed [23:0] suv;
    logic               rok;
    logic               known;
    reading_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dual_temp_sensor_validate_filter_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor copy of the registers and both filters
  longint ref_uv_cfg, offset_uv_cfg, slope_cfg, min_temp_cfg, max_temp_cfg;
  longint alpha_cfg, disagree_cfg;
  longint filt [2];
  bit     seeded [2];

  reading_t pending_readings [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic longint sensor_temp(longint uv);
    return ((uv - offset_uv_cfg) * slope_cfg) >>> TEMP_SHIFT;
  endfunction

  function automatic bit plausible(longint uv, longint t);
    return uv > MARGIN_UV && uv < ref_uv_cfg - MARGIN_UV &&
           t >= min_temp_cfg && t <= max_temp_cfg;
  endfunction

  // Seed on the first valid reading, then step the exponential filter
  function automatic longint smooth_channel(logic ch, longint t);
    longint a;
    a = (alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg;
    if (!seeded[ch]) begin
      filt[ch] = t * 65536;
      seeded[ch] = 1'b1;
    end else begin
      filt[ch] = filt[ch] + (((t * 65536 - filt[ch]) * a) >>> FRAC_W);
    end
    return filt[ch] >>> FRAC_W;
  endfunction

  function automatic reading_t predict_reading(logic [11:0] code, logic signed [23:0] suv,
                                               logic rok);
    longint p_uv, p_t, s_uv, s_t, p_rep, s_rep, gap;
    logic p_ok, s_ok;
    reading_t r;
    p_uv = longint'(code) * ref_uv_cfg / CODE_MAX;
    p_t = sensor_temp(p_uv);
    p_ok = longint'(code) > CODE_EDGE && longint'(code) < CODE_MAX - CODE_EDGE &&
           plausible(p_uv, p_t);
    p_rep = p_ok ? smooth_channel(CH_PRI, p_t) : 0;
    s_uv = longint'(suv);
    s_t = sensor_temp(s_uv);
    s_ok = rok && plausible(s_uv, s_t);
    s_rep = s_ok ? smooth_channel(CH_SEC, s_t) : 0;
    gap = (p_rep > s_rep) ? p_rep - s_rep : s_rep - p_rep;
    r = '0;
    r.pri_ok = p_ok;
    r.pri_temp = p_rep[TEMP_W-1:0];
    r.sec_ok = s_ok;
    r.sec_temp = s_rep[TEMP_W-1:0];
    r.agree = p_ok && s_ok && gap < disagree_cfg;
    r.proc_temp = (p_rep > s_rep) ? p_rep[TEMP_W-1:0] : s_rep[TEMP_W-1:0];
    return r;
  endfunction

  function automatic void store_setting(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
    case (idx)
      REG_REF_VOLTAGE:  ref_uv_cfg = longint'(value[REF_W-1:0]);
      REG_SENSOR_OFS:   offset_uv_cfg = longint'(value[OFS_W-1:0]);
      REG_INV_SLOPE:    slope_cfg = longint'(value[SLOPE_W-1:0]);
      REG_MIN_TEMP:     min_temp_cfg = longint'($signed(value[TEMP_W-1:0]));
      REG_MAX_TEMP:     max_temp_cfg = longint'($signed(value[TEMP_W-1:0]));
      REG_FILTER_ALPHA: alpha_cfg = longint'(value[ALPHA_W-1:0]);
      REG_MAX_DISAGREE: disagree_cfg = longint'(value[DIS_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Compare each result word with the oldest prediction; watchdog on quiet cycles
  always @(posedge clk) begin
    reading_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = reading_t'(m_tdata);
      if (pending_readings.size() == 0) begin
        $display("%0t: result expected none, got %h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("primary_ok", want.pri_ok, got.pri_ok);
        check_field("primary_temp", want.pri_temp, got.pri_temp);
        check_field("secondary_ok", want.sec_ok, got.sec_ok);
        check_field("secondary_temp", want.sec_temp, got.sec_temp);
        check_field("both_agree", want.agree, got.agree);
        check_field("process_temp", want.proc_temp, got.proc_temp);
        check_field("padding", want.pad, got.pad);
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_setting(idx, value);
  endtask

  // Offer one word, hold it until taken, predict at acceptance
  task automatic send_sample(input logic [11:0] code, input logic signed [23:0] suv,
                             input logic rok, input logic known, input reading_t want);
    reading_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({rok, suv, code});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_reading(code, suv, rok);
    pending_readings.push_back(known ? want : r);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Some readings aimed at the plausible window, some spread over the reference range, some raw noise
  task automatic make_sample(output logic [11:0] code, output logic signed [23:0] suv,
                             output logic rok);
    longint lo, hi, t, uv_s, uv_p, c, sl, rv;
    int pick;
    pick = $urandom_range(0, 99);
    sl = (slope_cfg == 0) ? 1 : slope_cfg;
    rv = (ref_uv_cfg == 0) ? 1 : ref_uv_cfg;
    lo = ((min_temp_cfg < max_temp_cfg) ? min_temp_cfg : max_temp_cfg) - 64;
    hi = ((min_temp_cfg < max_temp_cfg) ? max_temp_cfg : min_temp_cfg) + 64;
    if (pick < 40) begin
      t = lo + longint'($urandom_range(0, int'(hi - lo)));
      uv_s = offset_uv_cfg + (t <<< TEMP_SHIFT) / sl + longint'($urandom_range(0, 64)) - 32;
      t = t + longint'($urandom_range(0, 256)) - 128;
      uv_p = offset_uv_cfg + (t <<< TEMP_SHIFT) / sl;
      c = uv_p * CODE_MAX / rv + longint'($urandom_range(0, 2)) - 1;
      rok = ($urandom_range(0, 9) != 0);
    end else if (pick < 75) begin
      uv_s = longint'($urandom_range(0, int'(rv) + 200000)) - 100000;
      c = longint'($urandom_range(0, CODE_MAX));
      rok = ($urandom_range(0, 9) != 0);
    end else begin
      uv_s = longint'($signed(24'($urandom)));
      c = longint'($urandom_range(0, CODE_MAX));
      rok = 1'($urandom_range(0, 1));
    end
    if (c < 0) c = 0;
    if (c > CODE_MAX) c = CODE_MAX;
    if (uv_s < -8388608) uv_s = -8388608;
    if (uv_s > 8388607) uv_s = 8388607;
    code = c[11:0];
    suv = uv_s[23:0];
  endtask

  // Program all registers while idle, then run random words under one idling mode
  task automatic run_phase(input int rv, input int ofs, input int sl, input int mn,
                           input int mx, input int alpha, input int dis, input int n,
                           input int mode, input bit stress);
    logic [11:0] code;
    logic signed [23:0] suv;
    logic rok;
    wait_results_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_REF_VOLTAGE, 24'(rv));
    write_reg(REG_SENSOR_OFS, 24'(ofs));
    write_reg(REG_INV_SLOPE, 24'(sl));
    write_reg(REG_MIN_TEMP, 24'(mn));
    write_reg(REG_MAX_TEMP, 24'(mx));
    write_reg(REG_FILTER_ALPHA, 24'(alpha));
    write_reg(REG_MAX_DISAGREE, 24'(dis));
    write_reg(REG_SPARE, 24'($urandom));
    cfg_valid <= 1'b0;
    case (mode)
      1: begin tx_idle_pct = 49; rx_stall_pct = 0; end
      2: begin tx_idle_pct = 0; rx_stall_pct = 49; end
      3: begin tx_idle_pct = 25; rx_stall_pct = 25; end
      default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
    endcase
    for (int i = 0; i < n; i++) begin
      // back up the output while the sender keeps offering
      if (stress && i == 40) hold_req <= hold_req + 1;
      // pause the sender until everything is back
      if (stress && i == 120) wait_results_drained();
      make_sample(code, suv, rok);
      send_sample(code, suv, rok, 1'b0, '0);
    end
  endtask

  // Directed words at reset settings: known rows are all-invalid readings
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{12'd0,    24'sd0,        1'b0, 1'b1, '0},  // nothing valid after reset
    '{12'd4095, 24'sd8388607,  1'b1, 1'b1, '0},  // top code, top reading
    '{12'd5,    -24'sd8388608, 1'b1, 1'b1, '0},  // code at low edge, most negative
    '{12'd4090, 24'sd50000,    1'b1, 1'b1, '0},  // code at high edge, voltage margin
    '{12'd4089, 24'sd3250000,  1'b1, 1'b1, '0},  // primary above, secondary at upper voltage margin
    '{12'd6,    24'sd50001,    1'b0, 1'b1, '0},  // low voltage, read failed
    '{12'd1241, 24'sd1000000,  1'b1, 1'b0, '0},  // seed both filters
    '{12'd2000, 24'sd1600000,  1'b1, 1'b0, '0},
    '{12'd3000, 24'sd2000000,  1'b1, 1'b0, '0},  // both above max temp
    '{12'd1241, 24'sd1000000,  1'b0, 1'b0, '0},  // secondary read failed
    '{12'd700,  -24'sd100000,  1'b1, 1'b0, '0},  // only primary valid
    '{12'd400,  24'sd300000,   1'b1, 1'b0, '0},  // below zero degrees
    '{12'd100,  24'sd250000,   1'b1, 1'b0, '0},  // primary under min temp
    '{12'd1500, 24'sd3249999,  1'b1, 1'b0, '0},  // secondary just inside margin
    '{12'd4089, 24'sd1200000,  1'b1, 1'b0, '0},
    '{12'd1800, 24'sd1350000,  1'b1, 1'b0, '0},
    '{12'd1800, 24'sd1350000,  1'b1, 1'b0, '0}
  };

  initial begin
    int a, b;
    ref_uv_cfg = longint'(REF_RST);
    offset_uv_cfg = longint'(OFS_RST);
    slope_cfg = longint'(SLOPE_RST);
    min_temp_cfg = longint'(MIN_RST);
    max_temp_cfg = longint'(MAX_RST);
    alpha_cfg = longint'(ALPHA_RST);
    disagree_cfg = longint'(DIS_RST);
    filt[CH_PRI] = 0;
    filt[CH_SEC] = 0;
    seeded[CH_PRI] = 1'b0;
    seeded[CH_SEC] = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_sample(directed_rows[i].code, directed_rows[i].suv, directed_rows[i].rok,
                  directed_rows[i].known, directed_rows[i].want);

    // fixed settings: default scaling with stress, extremes, alpha above one, tiny reference
    run_phase(3300000, 500000, 429497, -32768, 32767, 6554, 5120, 200, 0, 1'b1);
    run_phase(6000000, 2097151, 16777215, -32768, 32767, 65536, 32767, 150, 1, 1'b0);
    run_phase(1000000, 0, 1, 0, 0, 0, 0, 150, 2, 1'b0);
    run_phase(8388607, 1000000, 1000000, -1000, 20000, 131071, 1, 150, 3, 1'b0);
    run_phase(80000, 500000, 0, 32767, -32768, 1, 5120, 60, 0, 1'b0);

    // random settings inside the usual ranges
    for (int p = 1; p <= 3; p++) begin
      a = $urandom_range(0, 65535) - 32768;
      b = $urandom_range(0, 65535) - 32768;
      run_phase($urandom_range(1000000, 6000000), $urandom_range(0, 2000000),
                $urandom_range(100000, 2000000), (a < b) ? a : b, (a < b) ? b : a,
                $urandom_range(0, 65536), $urandom_range(0, 32767), 150, p, 1'b0);
    end

    wait_results_drained();
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dtsvf_pkg.sv
hw/rtl/dual_temp_sensor_validate_filter_unit.sv
test/testbench.sv
